/* design/i2p_pkg.sv */
// ============================================================================
// i2p_pkg
// Shared types, character codes and helper functions for the infix to
// postfix converter.
// ============================================================================
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [7:0]       char_t;

  localparam char_t CH_OPEN  = 8'h28;
  localparam char_t CH_CLOSE = 8'h29;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_SLASH = 8'h2F;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_UNMATCH  = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] out_kind;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_PUSH    = 2'd1,
    OP_POP     = 2'd2,
    OP_REPLACE = 2'd3
  } stack_op_t;

  typedef struct packed {
    stack_op_t op;
    char_t     din;
  } stack_ctl_t;

  function automatic logic signed [2:0] prec_of(input char_t c);
    logic signed [2:0] p;
    p = -3'sd1;
    if (c == CH_OPEN) begin
      p = 3'sd0;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 3'sd1;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 3'sd2;
    end
    return p;
  endfunction

  function automatic logic is_alnum(input char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

/* design/i2p_cell.sv */
// ============================================================================
// i2p_cell
// One entry of the operator stack; loads from its upper neighbor on a push
// or a replace and from its lower neighbor on a pop.
// ============================================================================
module i2p_cell (
  input  logic              clk,
  input  i2p_pkg::stack_op_t op,
  input  i2p_pkg::char_t    from_above,
  input  i2p_pkg::char_t    from_below,
  output i2p_pkg::char_t    data
);

  i2p_pkg::char_t data_r;
  i2p_pkg::char_t data_nxt;

  always_comb begin
    unique case (op)
      i2p_pkg::OP_PUSH:    data_nxt = from_above;
      i2p_pkg::OP_POP:     data_nxt = from_below;
      i2p_pkg::OP_REPLACE: data_nxt = from_above;
      default:             data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* design/i2p_ctrl.sv */
// ============================================================================
// i2p_ctrl
// Sequencer: holds the current transaction, tracks the stack fill and makes
// at most one stack move and at most one result per step.
// ============================================================================
module i2p_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2p_pkg::in_item_t    in_item,
  input  logic                 slot_free,
  input  i2p_pkg::char_t       top_data,
  input  i2p_pkg::char_t       next_data,
  output i2p_pkg::stack_ctl_t  ctl,
  output logic                 res_valid,
  output i2p_pkg::out_item_t   res
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WORK = 2'b10
  } state_t;

  state_t         state_r, state_nxt;
  i2p_pkg::cnt_t  cnt_r, cnt_nxt;
  i2p_pkg::char_t sym_r, sym_nxt;
  logic           eot_r, eot_nxt;

  logic              empty, full, has_two;
  logic signed [2:0] p_sym;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == i2p_pkg::cnt_t'(i2p_pkg::STACK_DEPTH));
  assign has_two = (cnt_r >= i2p_pkg::cnt_t'(2));
  assign p_sym   = i2p_pkg::prec_of(sym_r);

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sym_nxt   = sym_r;
    eot_nxt   = eot_r;
    ctl.op    = i2p_pkg::OP_HOLD;
    ctl.din   = sym_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sym_nxt   = in_item.symbol;
          eot_nxt   = in_item.end_of_text;
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (slot_free) begin
          priority if (eot_r) begin
            res_valid = 1'b1;
            if (!empty) begin
              res.out_char = top_data;
              res.out_kind = i2p_pkg::KIND_CHAR;
              ctl.op       = i2p_pkg::OP_POP;
              cnt_nxt      = cnt_r - i2p_pkg::cnt_t'(1);
            end else begin
              res.out_kind    = i2p_pkg::KIND_END;
              res.last_of_run = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end else if (i2p_pkg::is_alnum(sym_r)) begin
            res_valid       = 1'b1;
            res.out_char    = sym_r;
            res.out_kind    = i2p_pkg::KIND_CHAR;
            res.last_of_run = 1'b1;
            state_nxt       = ST_IDLE;
          end else if (sym_r == i2p_pkg::CH_OPEN) begin
            state_nxt = ST_IDLE;
            if (full) begin
              res_valid       = 1'b1;
              res.out_kind    = i2p_pkg::KIND_OVERFLOW;
              res.last_of_run = 1'b1;
            end else begin
              ctl.op  = i2p_pkg::OP_PUSH;
              cnt_nxt = cnt_r + i2p_pkg::cnt_t'(1);
            end
          end else if (sym_r == i2p_pkg::CH_CLOSE) begin
            priority if (empty) begin
              res_valid       = 1'b1;
              res.out_kind    = i2p_pkg::KIND_UNMATCH;
              res.last_of_run = 1'b1;
              state_nxt       = ST_IDLE;
            end else if (top_data == i2p_pkg::CH_OPEN) begin
              ctl.op    = i2p_pkg::OP_POP;
              cnt_nxt   = cnt_r - i2p_pkg::cnt_t'(1);
              state_nxt = ST_IDLE;
            end else begin
              res_valid       = 1'b1;
              res.out_char    = top_data;
              res.out_kind    = i2p_pkg::KIND_CHAR;
              res.last_of_run = has_two && (next_data == i2p_pkg::CH_OPEN);
              ctl.op          = i2p_pkg::OP_POP;
              cnt_nxt         = cnt_r - i2p_pkg::cnt_t'(1);
            end
          end else begin
            priority if (!empty && (i2p_pkg::prec_of(top_data) >= p_sym)) begin
              res_valid    = 1'b1;
              res.out_char = top_data;
              res.out_kind = i2p_pkg::KIND_CHAR;
              if (has_two && (i2p_pkg::prec_of(next_data) >= p_sym)) begin
                ctl.op  = i2p_pkg::OP_POP;
                cnt_nxt = cnt_r - i2p_pkg::cnt_t'(1);
              end else begin
                res.last_of_run = 1'b1;
                ctl.op          = i2p_pkg::OP_REPLACE;
                state_nxt       = ST_IDLE;
              end
            end else if (full) begin
              res_valid       = 1'b1;
              res.out_kind    = i2p_pkg::KIND_OVERFLOW;
              res.last_of_run = 1'b1;
              state_nxt       = ST_IDLE;
            end else begin
              ctl.op    = i2p_pkg::OP_PUSH;
              cnt_nxt   = cnt_r + i2p_pkg::cnt_t'(1);
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    eot_r <= eot_nxt;
  end

endmodule

/* design/infix_to_postfix_converter.sv */
// ============================================================================
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream to postfix, with
// the operator stack held in a row of shifting cells.
// ============================================================================
// One transaction is taken, then worked off in steps while in_stall is high:
// one step per result, one per '(' dropped by a close paren and one for a
// push that makes no result. An operator that pops entries ends with a
// replace, since the last pop and the push share a step; a flush ends with
// the end marker. The sequencer makes at most one stack move per cycle, and
// a step waits while the output register holds a result under stall.
module infix_to_postfix_converter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2p_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output i2p_pkg::out_item_t  out_item
);

  i2p_pkg::stack_ctl_t ctl;
  i2p_pkg::out_item_t  res;
  logic                res_valid;
  logic                slot_free;
  i2p_pkg::char_t      cell_data [i2p_pkg::STACK_DEPTH];

  logic               out_valid_r, out_valid_nxt;
  i2p_pkg::out_item_t out_item_r, out_item_nxt;

  assign slot_free = !out_valid_r || !out_stall;

  i2p_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .slot_free (slot_free),
    .top_data  (cell_data[0]),
    .next_data (cell_data[1]),
    .ctl       (ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  for (genvar i = 0; i < i2p_pkg::STACK_DEPTH; i++) begin : g_cell
    i2p_pkg::stack_op_t cell_op;
    i2p_pkg::char_t     above;
    i2p_pkg::char_t     below;

    if (i == 0) begin : g_head
      assign cell_op = ctl.op;
      assign above   = ctl.din;
    end else begin : g_body
      assign cell_op = (ctl.op == i2p_pkg::OP_REPLACE) ? i2p_pkg::OP_HOLD : ctl.op;
      assign above   = cell_data[i-1];
    end

    if (i == i2p_pkg::STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_link
      assign below = cell_data[i+1];
    end

    i2p_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .from_above (above),
      .from_below (below),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (slot_free) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_item_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
